FILE: rtl/core/rtc_pkg.sv
// shared constants and types for the resolvent tautology check core
`default_nettype none

package rtc_pkg;

    localparam int MAX_LITS  = 64;
    localparam int VAR_BITS  = 20;
    localparam int ADDR_BITS = $clog2(MAX_LITS);
    localparam int LEN_BITS  = $clog2(MAX_LITS + 1);
    localparam int LIT_BITS  = VAR_BITS + 1;

    localparam logic [1:0] CLASH_SAT = 2'd2;

    localparam logic KIND_A = 1'b0;
    localparam logic KIND_B = 1'b1;

    localparam logic MODE_MERGE = 1'b0;
    localparam logic MODE_PAIRS = 1'b1;

    // stored literal: sign on top, variable below
    typedef struct packed {
        logic                neg;
        logic [VAR_BITS-1:0] var_idx;
    } lit_t;

    // outcome of one literal compare
    typedef struct packed {
        logic lt;
        logic eq;
        logic clash;
    } cmp_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/resolvent_tautology_check_core.sv
// top level: sequencer walking the clause a store with one shared comparator
//
// channel   direction  handshake               payload
// item      in         start & !busy           kind, var_index, negated, last
// result    out        done (one-cycle strobe) tautological, clash_count, store_overflow
// config    in         cfg_valid & cfg_ready   cfg_data (pairing mode)
//
// an a literal is written to the store as it is accepted and busy stays low
// a b literal takes a read state and a compare state per stored entry compared, then the
// done state, and another read state when the walk runs off the end of the store: all-pairs
// mode compares every stored entry, merge mode only those from the pointer to the first not
// below b; the read state covers the registered read of the store feeding one comparator
// the result strobe rises in the cycle after the done state of the last b literal
// reset empties the clause state and selects merge mode; the receiver cannot stall results
`default_nettype none

module resolvent_tautology_check_core (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        start,
    output logic       busy,
    input  wire        kind,
    input  wire [19:0] var_index,
    input  wire        negated,
    input  wire        last,
    output logic       done,
    output logic       tautological,
    output logic [1:0] clash_count,
    output logic       store_overflow,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire        cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic                           mode_reg, mode_next;
    logic [rtc_pkg::LEN_BITS-1:0]   a_len_reg, a_len_next;
    logic [rtc_pkg::LEN_BITS-1:0]   merge_ptr_reg, merge_ptr_next;
    logic [rtc_pkg::LEN_BITS-1:0]   idx_reg, idx_next;
    logic [1:0]                     clash_cnt_reg, clash_cnt_next;
    logic                           ovf_reg, ovf_next;
    logic                           done_reg, done_next;
    logic                           taut_reg, taut_next;
    logic [1:0]                     cnt_out_reg, cnt_out_next;
    logic                           ovf_out_reg, ovf_out_next;

    rtc_pkg::lit_t b_lit_reg, b_lit_next;
    logic          last_reg, last_next;

    logic              accept;
    logic              wr_en;
    logic              rd_en;
    rtc_pkg::lit_t     wr_lit;
    rtc_pkg::lit_t     rd_lit;
    rtc_pkg::cmp_res_t cmp;
    logic [1:0]        bumped_cnt;

    assign busy      = state_reg != ST_IDLE;
    assign cfg_ready = !busy;
    assign accept    = start && !busy;

    assign wr_lit.neg     = negated;
    assign wr_lit.var_idx = var_index[rtc_pkg::VAR_BITS-1:0];
    assign wr_en = accept && (kind == rtc_pkg::KIND_A)
                   && (a_len_reg < rtc_pkg::LEN_BITS'(rtc_pkg::MAX_LITS));

    rtc_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (a_len_reg[rtc_pkg::ADDR_BITS-1:0]),
        .wr_data (wr_lit),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[rtc_pkg::ADDR_BITS-1:0]),
        .rd_data (rd_lit)
    );

    rtc_cmp u_cmp (
        .a_lit (rd_lit),
        .b_lit (b_lit_reg),
        .res   (cmp)
    );

    // saturating clash increment
    assign bumped_cnt = (clash_cnt_reg == rtc_pkg::CLASH_SAT)
                        ? clash_cnt_reg : clash_cnt_reg + 2'd1;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        a_len_next     = a_len_reg;
        merge_ptr_next = merge_ptr_reg;
        idx_next       = idx_reg;
        clash_cnt_next = clash_cnt_reg;
        ovf_next       = ovf_reg;
        done_next      = 1'b0;
        taut_next      = taut_reg;
        cnt_out_next   = cnt_out_reg;
        ovf_out_next   = ovf_out_reg;
        b_lit_next     = b_lit_reg;
        last_next      = last_reg;
        rd_en          = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            mode_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind == rtc_pkg::KIND_A)
                    begin
                        if (wr_en)
                        begin
                            a_len_next = a_len_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else
                    begin
                        b_lit_next = wr_lit;
                        last_next  = last;
                        idx_next   = (mode_reg == rtc_pkg::MODE_PAIRS)
                                     ? '0 : merge_ptr_reg;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (idx_reg < a_len_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_CMP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CMP:
            begin
                if (mode_reg == rtc_pkg::MODE_PAIRS)
                begin
                    if (cmp.clash)
                    begin
                        clash_cnt_next = bumped_cnt;
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_READ;
                end
                else
                begin
                    priority if (cmp.lt)
                    begin
                        idx_next       = idx_reg + 1'b1;
                        merge_ptr_next = idx_reg + 1'b1;
                        state_next     = ST_READ;
                    end
                    else if (cmp.eq)
                    begin
                        if (cmp.clash)
                        begin
                            clash_cnt_next = bumped_cnt;
                        end
                        merge_ptr_next = idx_reg + 1'b1;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        merge_ptr_next = idx_reg;
                        state_next     = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (last_reg)
                begin
                    done_next      = 1'b1;
                    taut_next      = clash_cnt_reg == rtc_pkg::CLASH_SAT;
                    cnt_out_next   = clash_cnt_reg;
                    ovf_out_next   = ovf_reg;
                    a_len_next     = '0;
                    merge_ptr_next = '0;
                    clash_cnt_next = '0;
                    ovf_next       = 1'b0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= rtc_pkg::MODE_MERGE;
            a_len_reg     <= '0;
            merge_ptr_reg <= '0;
            idx_reg       <= '0;
            clash_cnt_reg <= '0;
            ovf_reg       <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            a_len_reg     <= a_len_next;
            merge_ptr_reg <= merge_ptr_next;
            idx_reg       <= idx_next;
            clash_cnt_reg <= clash_cnt_next;
            ovf_reg       <= ovf_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        taut_reg    <= taut_next;
        cnt_out_reg <= cnt_out_next;
        ovf_out_reg <= ovf_out_next;
        b_lit_reg   <= b_lit_next;
        last_reg    <= last_next;
    end

    assign done           = done_reg;
    assign tautological   = taut_reg;
    assign clash_count    = cnt_out_reg;
    assign store_overflow = ovf_out_reg;

    a_done_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_DONE))
        else $error("result strobe without a finished b literal");

    a_taut_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (tautological == (clash_count == rtc_pkg::CLASH_SAT)))
        else $error("tautology flag disagrees with clash count");

    a_store_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (a_len_reg == '0 && merge_ptr_reg == '0 && clash_cnt_reg == '0))
        else $error("clause state not cleared after result");

    a_ptr_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        merge_ptr_reg <= a_len_reg)
        else $error("merge pointer beyond stored clause");

endmodule

`default_nettype wire

FILE: rtl/core/rtc_store.sv
// clause a literal store, one write port and one registered read port
`default_nettype none

module rtc_store (
    input  wire                               clk,
    input  wire                               wr_en,
    input  wire  [rtc_pkg::ADDR_BITS-1:0]     wr_addr,
    input  wire  rtc_pkg::lit_t               wr_data,
    input  wire                               rd_en,
    input  wire  [rtc_pkg::ADDR_BITS-1:0]     rd_addr,
    output rtc_pkg::lit_t                     rd_data
);

    rtc_pkg::lit_t mem [rtc_pkg::MAX_LITS];
    rtc_pkg::lit_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/rtc_cmp.sv
// shared literal comparator: ordering, match and opposite-sign clash
`default_nettype none

module rtc_cmp (
    input  wire rtc_pkg::lit_t a_lit,
    input  wire rtc_pkg::lit_t b_lit,
    output rtc_pkg::cmp_res_t  res
);

    always_comb
    begin
        res.lt    = a_lit.var_idx < b_lit.var_idx;
        res.eq    = a_lit.var_idx == b_lit.var_idx;
        res.clash = (a_lit.var_idx == b_lit.var_idx) && (a_lit.neg != b_lit.neg);
    end

endmodule

`default_nettype wire
